@@ sv/mrts_pkg.sv @@
// Shared types and constants for the motor ramp test sequencer.
`default_nettype none

package mrts_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_UP       = 3'd1,
        MODE_COAST_HI = 3'd2,
        MODE_DOWN     = 3'd3,
        MODE_COAST_LO = 3'd4,
        MODE_STOPPED  = 3'd5,
        MODE_REVERSE  = 3'd6,
        MODE_STALLED  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_RAMP_STEP     = 3'd0,
        REG_COAST         = 3'd1,
        REG_STOP          = 3'd2,
        REG_REVERSE       = 3'd3,
        REG_STALL_SPEED   = 3'd4,
        REG_STALL_TIMEOUT = 3'd5,
        REG_RAMP_FLOOR    = 3'd6,
        REG_UNUSED        = 3'd7
    } reg_index_t;

    localparam int TIMER_W  = 16;
    localparam int SPEED_W  = 14;
    localparam int TARGET_W = 8;
    localparam int SUM_W    = 11;
    localparam int PULSE_W  = 4;
    localparam int CFG_W    = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    localparam logic [TIMER_W-1:0]  RAMP_STEP_RST     = 16'd20;
    localparam logic [TIMER_W-1:0]  COAST_RST         = 16'd3000;
    localparam logic [TIMER_W-1:0]  STOP_RST          = 16'd2000;
    localparam logic [TIMER_W-1:0]  REVERSE_RST       = 16'd500;
    localparam logic [SPEED_W-1:0]  STALL_SPEED_RST   = 14'd10;
    localparam logic [TIMER_W-1:0]  STALL_TIMEOUT_RST = 16'd1000;
    localparam logic [TARGET_W-1:0] RAMP_FLOOR_RST    = 8'd25;

endpackage

`default_nettype wire

@@ sv/motor_ramp_test_sequencer.sv @@
// Motor ramp test sequencer with windowed speed measurement and stall detection.
// A transaction accepted at s_ is held in the input register, then moves to the
// result register and is presented at m_ once the result register is free.
// Throughput: one transaction per cycle while m_tready takes results; all tick
// work is one pass of logic between the input register and the result register.
// Reset (aresetn low, synchronous) clears both pipeline stages, the sequencer
// state and the speed window, and loads the default configuration.
`default_nettype none

module motor_ramp_test_sequencer #(
    parameter int FULL_SPEED = 255,
    parameter int WINDOW_MS  = 100
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // op[1:0], pulses[5:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // set_speed[7:0], forward[8], mode[11:9],
                                        // speed_pps[25:12], stalled[26]
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int TW = mrts_pkg::TIMER_W;
    localparam int SW = mrts_pkg::SPEED_W;
    localparam int GW = mrts_pkg::TARGET_W;
    localparam int UW = mrts_pkg::SUM_W;
    localparam int WinW = $clog2(WINDOW_MS + 1);
    localparam int RecipShift = UW + 1 + $clog2(WINDOW_MS);
    localparam longint unsigned RecipMult =
        ((64'd1000 << RecipShift) + WINDOW_MS - 1) / WINDOW_MS;
    localparam int RecipW = $clog2(RecipMult + 1);
    localparam int ProdW = UW + RecipW;

    localparam logic [GW-1:0]     FullSpeed = GW'(FULL_SPEED);
    localparam logic [WinW-1:0]   WinLast   = WinW'(WINDOW_MS);
    localparam logic [RecipW-1:0] RecipM    = RecipMult[RecipW-1:0];

    logic [TW-1:0] ramp_step_reg, coast_reg, stop_reg, reverse_reg, stall_timeout_reg;
    logic [SW-1:0] stall_speed_reg;
    logic [GW-1:0] ramp_floor_reg;

    logic              in_valid_reg;
    mrts_pkg::op_t     in_op_reg;
    logic [3:0]        in_pulses_reg;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;

    mrts_pkg::mode_t   mode_reg, mode_next;
    logic [GW-1:0]     target_reg, target_next;
    logic              direction_reg, direction_next;
    logic [TW-1:0]     phase_reg, phase_next;
    logic [TW-1:0]     ramp_reg, ramp_next;
    logic [TW-1:0]     stall_timer_reg, stall_timer_next;
    logic              armed_reg, armed_next;
    logic [WinW-1:0]   window_reg, window_next;
    logic [UW-1:0]     sum_reg, sum_next;
    logic [SW-1:0]     speed_reg, speed_next;

    logic [UW:0]       sum_wide;
    logic [UW-1:0]     sum_sat;
    logic [ProdW-1:0]  prod;
    logic [ProdW-1:0]  quo;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg     <= mrts_pkg::RAMP_STEP_RST;
            coast_reg         <= mrts_pkg::COAST_RST;
            stop_reg          <= mrts_pkg::STOP_RST;
            reverse_reg       <= mrts_pkg::REVERSE_RST;
            stall_speed_reg   <= mrts_pkg::STALL_SPEED_RST;
            stall_timeout_reg <= mrts_pkg::STALL_TIMEOUT_RST;
            ramp_floor_reg    <= mrts_pkg::RAMP_FLOOR_RST;
        end else if (cfg_wr_en) begin
            unique case (mrts_pkg::reg_index_t'(cfg_index))
                mrts_pkg::REG_RAMP_STEP:     ramp_step_reg     <= cfg_wdata;
                mrts_pkg::REG_COAST:         coast_reg         <= cfg_wdata;
                mrts_pkg::REG_STOP:          stop_reg          <= cfg_wdata;
                mrts_pkg::REG_REVERSE:       reverse_reg       <= cfg_wdata;
                mrts_pkg::REG_STALL_SPEED:   stall_speed_reg   <= cfg_wdata[SW-1:0];
                mrts_pkg::REG_STALL_TIMEOUT: stall_timeout_reg <= cfg_wdata;
                mrts_pkg::REG_RAMP_FLOOR:    ramp_floor_reg    <= cfg_wdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg     <= mrts_pkg::op_t'(s_tdata[1:0]);
            in_pulses_reg <= s_tdata[5:2];
        end
        if (advance) begin
            out_data_reg <= {5'd0, (mode_next == mrts_pkg::MODE_STALLED), speed_next,
                             mode_next, direction_next, target_next};
        end
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= mrts_pkg::MODE_IDLE;
            target_reg      <= '0;
            direction_reg   <= 1'b1;
            phase_reg       <= '0;
            ramp_reg        <= '0;
            stall_timer_reg <= '0;
            armed_reg       <= 1'b0;
            window_reg      <= '0;
            sum_reg         <= '0;
            speed_reg       <= '0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            target_reg      <= target_next;
            direction_reg   <= direction_next;
            phase_reg       <= phase_next;
            ramp_reg        <= ramp_next;
            stall_timer_reg <= stall_timer_next;
            armed_reg       <= armed_next;
            window_reg      <= window_next;
            sum_reg         <= sum_next;
            speed_reg       <= speed_next;
        end
    end

    assign sum_wide = {1'b0, sum_reg} + {{(UW + 1 - mrts_pkg::PULSE_W){1'b0}}, in_pulses_reg};
    assign sum_sat  = sum_wide[UW] ? mrts_pkg::SUM_MAX : sum_wide[UW-1:0];
    assign prod     = ProdW'(sum_sat) * ProdW'(RecipM);
    assign quo      = prod >> RecipShift;

    always_comb begin
        mode_next        = mode_reg;
        target_next      = target_reg;
        direction_next   = direction_reg;
        phase_next       = phase_reg;
        ramp_next        = ramp_reg;
        stall_timer_next = stall_timer_reg;
        armed_next       = armed_reg;
        window_next      = window_reg;
        sum_next         = sum_reg;
        speed_next       = speed_reg;

        case (in_op_reg)
            mrts_pkg::OP_TICK: begin
                if (phase_reg != mrts_pkg::TIMER_MAX) begin
                    phase_next = phase_reg + 1'b1;
                end
                if (ramp_reg != mrts_pkg::TIMER_MAX) begin
                    ramp_next = ramp_reg + 1'b1;
                end

                sum_next    = sum_sat;
                window_next = window_reg + 1'b1;
                if (window_next >= WinLast) begin
                    if (quo > ProdW'(mrts_pkg::SPEED_MAX)) begin
                        speed_next = mrts_pkg::SPEED_MAX;
                    end else begin
                        speed_next = quo[SW-1:0];
                    end
                    sum_next    = '0;
                    window_next = '0;
                end

                if (target_reg != '0 && speed_next < stall_speed_reg) begin
                    if (!armed_reg) begin
                        armed_next       = 1'b1;
                        stall_timer_next = '0;
                    end else begin
                        if (stall_timer_reg != mrts_pkg::TIMER_MAX) begin
                            stall_timer_next = stall_timer_reg + 1'b1;
                        end
                        if (stall_timer_next >= stall_timeout_reg) begin
                            mode_next   = mrts_pkg::MODE_STALLED;
                            phase_next  = '0;
                            target_next = '0;
                            armed_next  = 1'b0;
                        end
                    end
                end else begin
                    armed_next = 1'b0;
                end

                unique case (mode_next)
                    mrts_pkg::MODE_UP: begin
                        if (ramp_next >= ramp_step_reg) begin
                            ramp_next = '0;
                            if (target_next < FullSpeed) begin
                                target_next = target_next + 1'b1;
                            end else begin
                                mode_next  = mrts_pkg::MODE_COAST_HI;
                                phase_next = '0;
                            end
                        end
                    end
                    mrts_pkg::MODE_COAST_HI: begin
                        if (phase_next >= coast_reg) begin
                            mode_next  = mrts_pkg::MODE_DOWN;
                            phase_next = '0;
                        end
                    end
                    mrts_pkg::MODE_DOWN: begin
                        if (ramp_next >= ramp_step_reg) begin
                            ramp_next = '0;
                            if (target_next > ramp_floor_reg) begin
                                target_next = target_next - 1'b1;
                            end else begin
                                mode_next  = mrts_pkg::MODE_COAST_LO;
                                phase_next = '0;
                            end
                        end
                    end
                    mrts_pkg::MODE_COAST_LO: begin
                        if (phase_next >= coast_reg) begin
                            mode_next   = mrts_pkg::MODE_STOPPED;
                            phase_next  = '0;
                            target_next = '0;
                        end
                    end
                    mrts_pkg::MODE_STOPPED: begin
                        if (phase_next >= stop_reg) begin
                            mode_next  = mrts_pkg::MODE_REVERSE;
                            phase_next = '0;
                        end
                    end
                    mrts_pkg::MODE_REVERSE: begin
                        if (phase_next >= reverse_reg) begin
                            direction_next = !direction_reg;
                            mode_next      = mrts_pkg::MODE_UP;
                            phase_next     = '0;
                        end
                    end
                    default: ;
                endcase
            end
            mrts_pkg::OP_START: begin
                if (mode_reg != mrts_pkg::MODE_STALLED) begin
                    mode_next  = mrts_pkg::MODE_UP;
                    phase_next = '0;
                    armed_next = 1'b0;
                end
            end
            mrts_pkg::OP_STOP: begin
                mode_next   = mrts_pkg::MODE_IDLE;
                phase_next  = '0;
                target_next = '0;
                armed_next  = 1'b0;
            end
            default: ;
        endcase
    end

    a_stall_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26] == (m_tdata[11:9] == mrts_pkg::MODE_STALLED)))
        else $error("Stalled flag disagrees with the reported mode.");

    a_idle_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == mrts_pkg::MODE_STOPPED || mode_reg == mrts_pkg::MODE_STALLED)
            |-> (target_reg == '0))
        else $error("Target speed is nonzero while stopped or stalled.");

    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        target_reg <= FullSpeed)
        else $error("Target speed exceeds full speed.");

    a_window_range: assert property (@(posedge aclk) disable iff (!aresetn)
        window_reg < WinLast)
        else $error("Speed window timer ran past the window length.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == mrts_pkg::MODE_STALLED && !(advance && in_op_reg == mrts_pkg::OP_STOP))
            |=> (mode_reg == mrts_pkg::MODE_STALLED))
        else $error("Sequencer left the stalled state without a stop transaction.");

endmodule

`default_nettype wire

@@ sim/tb_motor_ramp_test_sequencer.sv @@
// Self-checking testbench for the motor ramp test sequencer stream block.
`timescale 1ns / 100ps

module tb_motor_ramp_test_sequencer;

    localparam int FULL_SPEED = 255;
    localparam int WINDOW_MS  = 100;

    typedef struct packed {
        logic                         stalled;
        logic [mrts_pkg::SPEED_W-1:0] speed_pps;
        mrts_pkg::mode_t              mode;
        logic                         forward;
        logic [7:0]                   set_speed;
    } motor_status_t;

    typedef struct packed {
        logic                         wr_cfg;
        mrts_pkg::op_t                op;
        logic [mrts_pkg::PULSE_W-1:0] pulses;
        mrts_pkg::reg_index_t         idx;
        logic [mrts_pkg::CFG_W-1:0]   val;
        logic                         typed;
        motor_status_t                want;
    } script_row_t;

    localparam motor_status_t AT_REST = '{stalled: 1'b0, speed_pps: '0,
                                          mode: mrts_pkg::MODE_IDLE,
                                          forward: 1'b1, set_speed: 8'd0};
    localparam motor_status_t UP_AT_ZERO = '{stalled: 1'b0, speed_pps: '0,
                                             mode: mrts_pkg::MODE_UP,
                                             forward: 1'b1, set_speed: 8'd0};
    localparam motor_status_t HELD_STALLED = '{stalled: 1'b1, speed_pps: '0,
                                               mode: mrts_pkg::MODE_STALLED, forward: 1'b1,
                                               set_speed: 8'd0};
    localparam motor_status_t NO_CHECK = '0;

    localparam script_row_t DIRECTED_SCRIPT [24] = '{
        '{1'b0, mrts_pkg::OP_TICK,  4'd15, mrts_pkg::REG_UNUSED, 16'd0, 1'b1, AT_REST},
        '{1'b0, mrts_pkg::OP_NONE,  4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, AT_REST},
        '{1'b0, mrts_pkg::OP_STOP,  4'd15, mrts_pkg::REG_UNUSED, 16'd0, 1'b1, AT_REST},
        '{1'b0, mrts_pkg::OP_TICK,  4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, AT_REST},
        '{1'b0, mrts_pkg::OP_START, 4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, UP_AT_ZERO},
        '{1'b0, mrts_pkg::OP_TICK,  4'd9,  mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b1, mrts_pkg::OP_NONE,  4'd0,  mrts_pkg::REG_RAMP_STEP, 16'd1, 1'b0, NO_CHECK},
        '{1'b1, mrts_pkg::OP_NONE,  4'd0,  mrts_pkg::REG_STALL_SPEED, 16'h3FFF, 1'b0,
          NO_CHECK},
        '{1'b1, mrts_pkg::OP_NONE,  4'd0,  mrts_pkg::REG_STALL_TIMEOUT, 16'd2, 1'b0,
          NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd6,  mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd10, mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd5,  mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, HELD_STALLED},
        '{1'b0, mrts_pkg::OP_START, 4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, HELD_STALLED},
        '{1'b0, mrts_pkg::OP_TICK,  4'd15, mrts_pkg::REG_UNUSED, 16'd0, 1'b1, HELD_STALLED},
        '{1'b0, mrts_pkg::OP_NONE,  4'd3,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, HELD_STALLED},
        '{1'b0, mrts_pkg::OP_STOP,  4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b1, AT_REST},
        '{1'b1, mrts_pkg::OP_NONE,  4'd0,  mrts_pkg::REG_STALL_SPEED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_START, 4'd12, mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd15, mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd15, mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd0,  mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd7,  mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK},
        '{1'b0, mrts_pkg::OP_TICK,  4'd15, mrts_pkg::REG_UNUSED, 16'd0, 1'b0, NO_CHECK}
    };

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [31:0]                m_tdata;
    logic                       cfg_wr_en;
    mrts_pkg::reg_index_t       cfg_index;
    logic [mrts_pkg::CFG_W-1:0] cfg_wdata;

    motor_status_t     expected_status_q[$];
    motor_status_t     got_status;
    motor_status_t     want_status;
    int                mismatches = 0;
    int                results_taken = 0;
    int                send_burst = 0;
    int                sink_burst = 0;

    mrts_pkg::mode_t               pred_mode    = mrts_pkg::MODE_IDLE;
    logic [mrts_pkg::TARGET_W-1:0] pred_target  = '0;
    logic                          pred_forward = 1'b1;
    logic [mrts_pkg::TIMER_W-1:0]  phase_ms     = '0;
    logic [mrts_pkg::TIMER_W-1:0]  ramp_ms      = '0;
    logic [mrts_pkg::TIMER_W-1:0]  stall_ms     = '0;
    logic                          stall_armed  = 1'b0;
    logic [6:0]                    window_ms    = '0;
    logic [mrts_pkg::SUM_W-1:0]    pulse_acc    = '0;
    logic [mrts_pkg::SPEED_W-1:0]  speed_meas   = '0;

    logic [mrts_pkg::TIMER_W-1:0]  cfg_ramp_step     = mrts_pkg::RAMP_STEP_RST;
    logic [mrts_pkg::TIMER_W-1:0]  cfg_coast         = mrts_pkg::COAST_RST;
    logic [mrts_pkg::TIMER_W-1:0]  cfg_stop          = mrts_pkg::STOP_RST;
    logic [mrts_pkg::TIMER_W-1:0]  cfg_reverse       = mrts_pkg::REVERSE_RST;
    logic [mrts_pkg::SPEED_W-1:0]  cfg_stall_speed   = mrts_pkg::STALL_SPEED_RST;
    logic [mrts_pkg::TIMER_W-1:0]  cfg_stall_timeout = mrts_pkg::STALL_TIMEOUT_RST;
    logic [mrts_pkg::TARGET_W-1:0] cfg_ramp_floor    = mrts_pkg::RAMP_FLOOR_RST;

    motor_ramp_test_sequencer #(
        .FULL_SPEED (FULL_SPEED),
        .WINDOW_MS  (WINDOW_MS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [mrts_pkg::TIMER_W-1:0] ms_sat_inc(
        input logic [mrts_pkg::TIMER_W-1:0] v);
        return (v == mrts_pkg::TIMER_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void enter_phase(input mrts_pkg::mode_t m);
        pred_mode = m;
        phase_ms  = '0;
    endfunction

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic predict_status(input mrts_pkg::op_t op,
                                  input logic [mrts_pkg::PULSE_W-1:0] pulses,
                                  output motor_status_t st);
        int acc;
        int scaled;
        case (op)
            mrts_pkg::OP_TICK: begin
                phase_ms = ms_sat_inc(phase_ms);
                ramp_ms  = ms_sat_inc(ramp_ms);

                acc = int'(pulse_acc) + int'(pulses);
                pulse_acc = (acc > int'(mrts_pkg::SUM_MAX)) ? mrts_pkg::SUM_MAX
                                                             : mrts_pkg::SUM_W'(acc);
                window_ms = window_ms + 1'b1;
                if (window_ms >= WINDOW_MS) begin
                    scaled = int'(pulse_acc) * 1000 / WINDOW_MS;
                    speed_meas = (scaled > int'(mrts_pkg::SPEED_MAX)) ? mrts_pkg::SPEED_MAX
                                                                       : mrts_pkg::SPEED_W'(scaled);
                    pulse_acc = '0;
                    window_ms = '0;
                end

                if (pred_target != '0 && speed_meas < cfg_stall_speed) begin
                    if (!stall_armed) begin
                        stall_armed = 1'b1;
                        stall_ms    = '0;
                    end else begin
                        stall_ms = ms_sat_inc(stall_ms);
                        if (stall_ms >= cfg_stall_timeout) begin
                            enter_phase(mrts_pkg::MODE_STALLED);
                            pred_target = '0;
                            stall_armed = 1'b0;
                        end
                    end
                end else begin
                    stall_armed = 1'b0;
                end

                case (pred_mode)
                    mrts_pkg::MODE_UP: begin
                        if (ramp_ms >= cfg_ramp_step) begin
                            ramp_ms = '0;
                            if (pred_target < FULL_SPEED) pred_target = pred_target + 1'b1;
                            else enter_phase(mrts_pkg::MODE_COAST_HI);
                        end
                    end
                    mrts_pkg::MODE_COAST_HI: begin
                        if (phase_ms >= cfg_coast) enter_phase(mrts_pkg::MODE_DOWN);
                    end
                    mrts_pkg::MODE_DOWN: begin
                        if (ramp_ms >= cfg_ramp_step) begin
                            ramp_ms = '0;
                            if (pred_target > cfg_ramp_floor) pred_target = pred_target - 1'b1;
                            else enter_phase(mrts_pkg::MODE_COAST_LO);
                        end
                    end
                    mrts_pkg::MODE_COAST_LO: begin
                        if (phase_ms >= cfg_coast) begin
                            enter_phase(mrts_pkg::MODE_STOPPED);
                            pred_target = '0;
                        end
                    end
                    mrts_pkg::MODE_STOPPED: begin
                        if (phase_ms >= cfg_stop) enter_phase(mrts_pkg::MODE_REVERSE);
                    end
                    mrts_pkg::MODE_REVERSE: begin
                        if (phase_ms >= cfg_reverse) begin
                            pred_forward = ~pred_forward;
                            enter_phase(mrts_pkg::MODE_UP);
                        end
                    end
                    default: ;
                endcase
            end
            mrts_pkg::OP_START: begin
                if (pred_mode != mrts_pkg::MODE_STALLED) begin
                    enter_phase(mrts_pkg::MODE_UP);
                    stall_armed = 1'b0;
                end
            end
            mrts_pkg::OP_STOP: begin
                enter_phase(mrts_pkg::MODE_IDLE);
                pred_target = '0;
                stall_armed = 1'b0;
            end
            default: ;
        endcase

        st.set_speed = pred_target;
        st.forward   = pred_forward;
        st.mode      = pred_mode;
        st.speed_pps = speed_meas;
        st.stalled   = (pred_mode == mrts_pkg::MODE_STALLED);
    endtask

    task automatic send_txn(input mrts_pkg::op_t op,
                            input logic [mrts_pkg::PULSE_W-1:0] pulses,
                            input logic typed, input motor_status_t want);
        int idle_cycles;
        motor_status_t predicted;
        idle_cycles = pick_gap(send_burst);
        for (int i = 0; i < idle_cycles; i++) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, pulses, op};
        do @(posedge aclk); while (!s_tready);
        predict_status(op, pulses, predicted);
        expected_status_q.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_setting(input mrts_pkg::reg_index_t idx,
                                 input logic [mrts_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            mrts_pkg::REG_RAMP_STEP:     cfg_ramp_step     = val;
            mrts_pkg::REG_COAST:         cfg_coast         = val;
            mrts_pkg::REG_STOP:          cfg_stop          = val;
            mrts_pkg::REG_REVERSE:       cfg_reverse       = val;
            mrts_pkg::REG_STALL_SPEED:   cfg_stall_speed   = val[mrts_pkg::SPEED_W-1:0];
            mrts_pkg::REG_STALL_TIMEOUT: cfg_stall_timeout = val;
            mrts_pkg::REG_RAMP_FLOOR:    cfg_ramp_floor    = val[mrts_pkg::TARGET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input int n, input int tick_pct, input int start_pct,
                             input int stop_pct);
        int r;
        mrts_pkg::op_t op;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (r < tick_pct) op = mrts_pkg::OP_TICK;
            else if (r < tick_pct + start_pct) op = mrts_pkg::OP_START;
            else if (r < tick_pct + start_pct + stop_pct) op = mrts_pkg::OP_STOP;
            else op = mrts_pkg::OP_NONE;
            send_txn(op, mrts_pkg::PULSE_W'($urandom_range(0, 15)), 1'b0, NO_CHECK);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_taken++;
            got_status = motor_status_t'(m_tdata[26:0]);
            if (expected_status_q.size() == 0) begin
                $error("result transaction arrived with no expectation pending");
                mismatches++;
            end else begin
                want_status = expected_status_q.pop_front();
                if (got_status.set_speed !== want_status.set_speed) begin
                    $error("set_speed: expected %0d, got %0d",
                           want_status.set_speed, got_status.set_speed);
                    mismatches++;
                end
                if (got_status.forward !== want_status.forward) begin
                    $error("forward: expected %0d, got %0d",
                           want_status.forward, got_status.forward);
                    mismatches++;
                end
                if (got_status.mode !== want_status.mode) begin
                    $error("mode: expected %0d, got %0d", want_status.mode, got_status.mode);
                    mismatches++;
                end
                if (got_status.speed_pps !== want_status.speed_pps) begin
                    $error("speed_pps: expected %0d, got %0d",
                           want_status.speed_pps, got_status.speed_pps);
                    mismatches++;
                end
                if (got_status.stalled !== want_status.stalled) begin
                    $error("stalled: expected %0d, got %0d",
                           want_status.stalled, got_status.stalled);
                    mismatches++;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch so that the pipeline backs up.
    initial begin : result_sink
        int idle_cycles;
        bit held_long;
        m_tready  = 1'b0;
        held_long = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            idle_cycles = pick_gap(sink_burst);
            if (!held_long && results_taken >= 150) begin
                idle_cycles = 80;
                held_long   = 1'b1;
            end
            for (int i = 0; i < idle_cycles; i++) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = mrts_pkg::REG_RAMP_STEP;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DIRECTED_SCRIPT[k]) begin
            if (DIRECTED_SCRIPT[k].wr_cfg) begin
                wait_drained();
                write_setting(DIRECTED_SCRIPT[k].idx, DIRECTED_SCRIPT[k].val);
            end else begin
                send_txn(DIRECTED_SCRIPT[k].op, DIRECTED_SCRIPT[k].pulses,
                         DIRECTED_SCRIPT[k].typed, DIRECTED_SCRIPT[k].want);
            end
        end

        // A full profile: ramp to full speed, coast, ramp down, stop and reverse.
        wait_drained();
        write_setting(mrts_pkg::REG_RAMP_STEP, 16'd1);
        write_setting(mrts_pkg::REG_COAST, 16'd2);
        write_setting(mrts_pkg::REG_STOP, 16'd0);
        write_setting(mrts_pkg::REG_REVERSE, 16'd0);
        write_setting(mrts_pkg::REG_STALL_SPEED, 16'd0);
        write_setting(mrts_pkg::REG_STALL_TIMEOUT, 16'd0);
        write_setting(mrts_pkg::REG_RAMP_FLOOR, 16'd250);
        run_phase(310, 97, 0, 0);

        // Stall detection with frequent start and stop commands.
        wait_drained();
        write_setting(mrts_pkg::REG_RAMP_STEP, 16'd2);
        write_setting(mrts_pkg::REG_COAST, 16'd0);
        write_setting(mrts_pkg::REG_STOP, 16'd1);
        write_setting(mrts_pkg::REG_REVERSE, 16'd3);
        write_setting(mrts_pkg::REG_STALL_SPEED, 16'h3FFF);
        write_setting(mrts_pkg::REG_STALL_TIMEOUT, mrts_pkg::CFG_W'($urandom_range(0, 12)));
        write_setting(mrts_pkg::REG_RAMP_FLOOR, 16'd0);
        run_phase(80, 75, 12, 6);

        // Largest timer and stall speed settings; the ramp floor gets a zero low byte.
        wait_drained();
        write_setting(mrts_pkg::REG_RAMP_STEP, 16'hFFFF);
        write_setting(mrts_pkg::REG_COAST, 16'hFFFF);
        write_setting(mrts_pkg::REG_STOP, 16'hFFFF);
        write_setting(mrts_pkg::REG_REVERSE, 16'hFFFF);
        write_setting(mrts_pkg::REG_STALL_SPEED, 16'hFFFF);
        write_setting(mrts_pkg::REG_STALL_TIMEOUT, 16'hFFFF);
        write_setting(mrts_pkg::REG_RAMP_FLOOR, 16'hFF00);
        write_setting(mrts_pkg::REG_UNUSED, 16'hA5A5);
        run_phase(60, 70, 10, 10);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("motor_ramp_test_sequencer: match");
        end else begin
            $display("motor_ramp_test_sequencer: mismatch");
        end
        $finish;
    end

    initial begin
        #2_400_000;
        $display("motor_ramp_test_sequencer: mismatch");
        $finish;
    end

endmodule

@@ motor_ramp_test_sequencer.f @@
sv/mrts_pkg.sv
sv/motor_ramp_test_sequencer.sv
sim/tb_motor_ramp_test_sequencer.sv
